/* rtl/u8d_pkg.sv */
// Shared types, constants and lookup functions for the UTF-8 DFA decoder.
package u8d_pkg;

  localparam int ByteW  = 8;
  localparam int ClsW   = 4;
  localparam int StateW = 4;
  localparam int CpW    = 21;
  localparam int PayW   = 6;

  // Front-to-back queue; depth must be a power of two
  localparam int QDepth = 2;
  localparam int QIdxW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // DFA state codes
  localparam logic [StateW-1:0] ST_ACCEPT = 4'd0;
  localparam logic [StateW-1:0] ST_REJECT = 4'd1;
  localparam logic [StateW-1:0] ST_NEED1  = 4'd2;  // one continuation byte owed
  localparam logic [StateW-1:0] ST_NEED2  = 4'd3;  // two continuation bytes owed
  localparam logic [StateW-1:0] ST_E0     = 4'd4;  // after E0, no overlong
  localparam logic [StateW-1:0] ST_ED     = 4'd5;  // after ED, no surrogate
  localparam logic [StateW-1:0] ST_F0     = 4'd6;  // after F0, no overlong
  localparam logic [StateW-1:0] ST_NEED3  = 4'd7;  // three continuation bytes owed
  localparam logic [StateW-1:0] ST_F4     = 4'd8;  // after F4, stay below 0x110000
  localparam logic [StateW-1:0] ST_MAX    = 4'd8;

  // Character class codes
  localparam logic [ClsW-1:0] CL_ASCII   = 4'd0;
  localparam logic [ClsW-1:0] CL_CONT_LO = 4'd1;
  localparam logic [ClsW-1:0] CL_LEAD2   = 4'd2;
  localparam logic [ClsW-1:0] CL_LEAD3   = 4'd3;
  localparam logic [ClsW-1:0] CL_LEAD_ED = 4'd4;
  localparam logic [ClsW-1:0] CL_LEAD_F4 = 4'd5;
  localparam logic [ClsW-1:0] CL_LEAD4   = 4'd6;
  localparam logic [ClsW-1:0] CL_CONT_HI = 4'd7;
  localparam logic [ClsW-1:0] CL_INVALID = 4'd8;
  localparam logic [ClsW-1:0] CL_CONT_MD = 4'd9;
  localparam logic [ClsW-1:0] CL_LEAD_E0 = 4'd10;
  localparam logic [ClsW-1:0] CL_LEAD_F0 = 4'd11;

  // One classified item in flight between front and back
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
    logic [ClsW-1:0]  cls;
  } u8d_item_t;

  // Byte to character class
  function automatic logic [ClsW-1:0] byte_class(input logic [ByteW-1:0] b);
    logic [ClsW-1:0] c;
    if (b <= 8'h7F)      c = CL_ASCII;
    else if (b <= 8'h8F) c = CL_CONT_LO;
    else if (b <= 8'h9F) c = CL_CONT_MD;
    else if (b <= 8'hBF) c = CL_CONT_HI;
    else if (b <= 8'hC1) c = CL_INVALID;
    else if (b <= 8'hDF) c = CL_LEAD2;
    else if (b == 8'hE0) c = CL_LEAD_E0;
    else if (b == 8'hED) c = CL_LEAD_ED;
    else if (b <= 8'hEF) c = CL_LEAD3;
    else if (b == 8'hF0) c = CL_LEAD_F0;
    else if (b <= 8'hF3) c = CL_LEAD4;
    else if (b == 8'hF4) c = CL_LEAD_F4;
    else                 c = CL_INVALID;
    return c;
  endfunction

  // DFA transition; any state outside the table acts as reject
  function automatic logic [StateW-1:0] next_state(input logic [StateW-1:0] s,
                                                   input logic [ClsW-1:0] c);
    logic [StateW-1:0] n;
    logic c_1, c_7, c_9;
    c_1 = (c == CL_CONT_LO);
    c_7 = (c == CL_CONT_HI);
    c_9 = (c == CL_CONT_MD);
    n = ST_REJECT;
    case (s)
      ST_ACCEPT: begin
        case (c)
          CL_ASCII:   n = ST_ACCEPT;
          CL_LEAD2:   n = ST_NEED1;
          CL_LEAD3:   n = ST_NEED2;
          CL_LEAD_ED: n = ST_ED;
          CL_LEAD_F4: n = ST_F4;
          CL_LEAD4:   n = ST_NEED3;
          CL_LEAD_E0: n = ST_E0;
          CL_LEAD_F0: n = ST_F0;
          default:    n = ST_REJECT;
        endcase
      end
      ST_NEED1: if (c_1 || c_7 || c_9) n = ST_ACCEPT;
      ST_NEED2: if (c_1 || c_7 || c_9) n = ST_NEED1;
      ST_E0:    if (c_7) n = ST_NEED1;
      ST_ED:    if (c_1 || c_9) n = ST_NEED1;
      ST_F0:    if (c_7 || c_9) n = ST_NEED2;
      ST_NEED3: if (c_1 || c_7 || c_9) n = ST_NEED2;
      ST_F4:    if (c_1) n = ST_NEED2;
      default:  n = ST_REJECT;
    endcase
    return n;
  endfunction

endpackage

/* rtl/utf8_dfa_decoder_unit.sv */
// Top level of the UTF-8 DFA decoder: classify front, queue, DFA back end.
//
//  channel  dir  tdata                              tuser / tlast
//  s_axis   in   [7:0] data_byte                    tlast = last_byte
//  m_axis   out  [20:0] code_point,                 tuser [0] char_complete,
//                [24:21] dfa_state_out, rest zero   [1] rejected, [2] string_valid
//
// One byte per cycle sustained while neither side stalls; a result passes through the
// classify register, the queue and the result register before it can leave.
// The DFA state and accumulator update in the back end once per byte; that loop
// sets the rate. rst clears all valid flags and returns the DFA to accept.
// Either side may stall on its own; the two-entry queue absorbs the difference.
module utf8_dfa_decoder_unit
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [20:0] code_point, [24:21] dfa_state_out
  output logic [2:0]  m_axis_tuser    // [0] char_complete, [1] rejected, [2] string_valid
);

  logic              fq_valid;
  logic              fq_ready;
  u8d_item_t         fq_item;
  logic              qb_valid;
  logic              qb_ready;
  u8d_item_t         qb_item;
  logic [CpW-1:0]    code_point;
  logic [StateW-1:0] dfa_state_out;
  logic              char_complete;
  logic              rejected;
  logic              string_valid;

  u8d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_valid (fq_valid),
    .out_ready (fq_ready),
    .out_item  (fq_item)
  );

  u8d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  u8d_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (qb_valid),
    .in_ready      (qb_ready),
    .in_item       (qb_item),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .code_point    (code_point),
    .dfa_state_out (dfa_state_out),
    .char_complete (char_complete),
    .rejected      (rejected),
    .string_valid  (string_valid)
  );

  // pack result fields
  assign m_axis_tdata = {{(32-CpW-StateW){1'b0}}, dfa_state_out, code_point};
  assign m_axis_tuser = {string_valid, rejected, char_complete};

endmodule

/* rtl/u8d_front.sv */
// Front end: takes input bytes, classifies them and holds one registered item.
module u8d_front
  import u8d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_byte,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_ready,
  output u8d_item_t        out_item
);

  logic      item_valid;
  u8d_item_t item;

  assign in_ready  = !item_valid || out_ready;
  assign out_valid = item_valid;
  assign out_item  = item;

  // valid flag of the stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // classify on the way in
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data_byte <= in_byte;
      item.last_byte <= in_last;
      item.cls       <= byte_class(in_byte);
    end
  end

endmodule

/* rtl/u8d_queue.sv */
// Two-entry queue that decouples the classify stage from the DFA stage.
module u8d_queue
  import u8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  u8d_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output u8d_item_t pop_item
);

  u8d_item_t         slots [QDepth];
  logic [QIdxW-1:0]  wr_ptr;
  logic [QIdxW-1:0]  rd_ptr;
  logic [QCntW-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCntW'(QDepth));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count; pointers wrap naturally at a power-of-two depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QIdxW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QIdxW'(1);
      count <= count + QCntW'(do_push) - QCntW'(do_pop);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == QCntW'(QDepth)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + QCntW'(1)))
    else $error("queue count did not advance on push");
`endif

endmodule

/* rtl/u8d_back.sv */
// Back end: runs the DFA, builds the code point and registers the result item.
module u8d_back
  import u8d_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  u8d_item_t         in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CpW-1:0]    code_point,
  output logic [StateW-1:0] dfa_state_out,
  output logic              char_complete,
  output logic              rejected,
  output logic              string_valid
);

  logic [StateW-1:0] dfa_state;
  logic [CpW-1:0]    code_accum;
  logic [StateW-1:0] cur_state;
  logic [StateW-1:0] new_state;
  logic [CpW-1:0]    accum_next;
  logic [ByteW-1:0]  lead_mask;
  logic              take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // transition and accumulator update
  always_comb begin
    cur_state = (dfa_state > ST_MAX) ? ST_REJECT : dfa_state;
    lead_mask = 8'hFF >> in_item.cls;
    if (cur_state != ST_ACCEPT) begin
      accum_next = {code_accum[CpW-PayW-1:0], in_item.data_byte[PayW-1:0]};
    end else begin
      accum_next = {{(CpW-ByteW){1'b0}}, lead_mask & in_item.data_byte};
    end
    new_state = next_state(cur_state, in_item.cls);
  end

  // decoder state; cleared after the last byte of a string
  always_ff @(posedge clk) begin
    if (rst) begin
      dfa_state  <= ST_ACCEPT;
      code_accum <= '0;
    end else if (take) begin
      dfa_state  <= in_item.last_byte ? ST_ACCEPT : new_state;
      code_accum <= in_item.last_byte ? '0 : accum_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      code_point    <= (new_state == ST_ACCEPT) ? accum_next : '0;
      dfa_state_out <= new_state;
      char_complete <= (new_state == ST_ACCEPT);
      rejected      <= (new_state == ST_REJECT);
      string_valid  <= in_item.last_byte && (new_state == ST_ACCEPT);
    end
  end

`ifndef SYNTHESIS
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(char_complete && rejected))
    else $error("complete and reject both set");
  a_complete_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_complete == (dfa_state_out == ST_ACCEPT)))
    else $error("complete flag disagrees with state");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (take && in_item.last_byte) |=> (dfa_state == ST_ACCEPT && code_accum == '0))
    else $error("state not cleared after last byte");
  a_reject_sticky: assert property (@(posedge clk) disable iff (rst)
    (take && dfa_state == ST_REJECT) |=> (dfa_state_out == ST_REJECT))
    else $error("reject state left before end of string");
  a_state_range: assert property (@(posedge clk) disable iff (rst)
    dfa_state <= ST_MAX)
    else $error("DFA state out of range");
`endif

endmodule

/* sim/utf8_dfa_decoder_unit_test.sv */
// Self-checking testbench for the UTF-8 DFA decoder: directed bytes, then random strings.
`timescale 1ns / 100ps

module utf8_dfa_decoder_unit_test;
  import u8d_pkg::*;

  localparam int RandomBytes = 1600;
  localparam int DrainCycles = 10;

  // One decoded result as seen on the master side
  typedef struct packed {
    logic [CpW-1:0]    cp;
    logic [StateW-1:0] st;
    logic              cc;
    logic              rej;
    logic              sv;
  } dec_result_t;

  // One stimulus row; typed rows carry their result written out by hand
  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             last;
    logic             typed;
    dec_result_t      res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [20:0] code_point, [24:21] dfa_state_out
  logic [2:0]  m_axis_tuser;           // [0] char_complete, [1] rejected, [2] string_valid

  stim_row_t   utf8_bytes[$];
  dec_result_t expected_decodes[$];

  logic [StateW-1:0] pred_state = ST_ACCEPT;
  logic [CpW-1:0]    pred_accum = '0;

  int  err_cnt   = 0;
  int  send_idle = 13;
  int  recv_idle = 82;
  bit  fill_test = 1'b0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  utf8_dfa_decoder_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // Byte to character class
  function automatic logic [ClsW-1:0] char_class_of(input logic [ByteW-1:0] b);
    if (b < 8'h80)       return CL_ASCII;
    else if (b < 8'h90)  return CL_CONT_LO;
    else if (b < 8'hA0)  return CL_CONT_MD;
    else if (b < 8'hC0)  return CL_CONT_HI;
    else if (b < 8'hC2)  return CL_INVALID;
    else if (b < 8'hE0)  return CL_LEAD2;
    else if (b == 8'hE0) return CL_LEAD_E0;
    else if (b == 8'hED) return CL_LEAD_ED;
    else if (b < 8'hF0)  return CL_LEAD3;
    else if (b == 8'hF0) return CL_LEAD_F0;
    else if (b < 8'hF4)  return CL_LEAD4;
    else if (b == 8'hF4) return CL_LEAD_F4;
    return CL_INVALID;
  endfunction

  // DFA transition; anything not listed falls into reject
  function automatic logic [StateW-1:0] dfa_advance(input logic [StateW-1:0] s,
                                                    input logic [ClsW-1:0] c);
    logic any_cont;
    any_cont = (c == CL_CONT_LO) || (c == CL_CONT_MD) || (c == CL_CONT_HI);
    case (s)
      ST_ACCEPT: begin
        case (c)
          CL_ASCII:   return ST_ACCEPT;
          CL_LEAD2:   return ST_NEED1;
          CL_LEAD3:   return ST_NEED2;
          CL_LEAD_ED: return ST_ED;
          CL_LEAD_F4: return ST_F4;
          CL_LEAD4:   return ST_NEED3;
          CL_LEAD_E0: return ST_E0;
          CL_LEAD_F0: return ST_F0;
          default:    return ST_REJECT;
        endcase
      end
      ST_NEED1: if (any_cont) return ST_ACCEPT;
      ST_NEED2: if (any_cont) return ST_NEED1;
      ST_E0:    if (c == CL_CONT_HI) return ST_NEED1;
      ST_ED:    if (c == CL_CONT_LO || c == CL_CONT_MD) return ST_NEED1;
      ST_F0:    if (c == CL_CONT_MD || c == CL_CONT_HI) return ST_NEED2;
      ST_NEED3: if (any_cont) return ST_NEED2;
      ST_F4:    if (c == CL_CONT_LO) return ST_NEED2;
      default:  return ST_REJECT;
    endcase
    return ST_REJECT;
  endfunction

  // Predict the result of one byte and advance the shadow decoder
  function automatic dec_result_t decode_byte(input logic [ByteW-1:0] b, input logic last);
    logic [ClsW-1:0]   c;
    logic [StateW-1:0] s;
    dec_result_t       r;
    c = char_class_of(b);
    s = (pred_state > ST_MAX) ? ST_REJECT : pred_state;
    // Lead byte masks off its length bits; later bytes add six payload bits
    if (s != ST_ACCEPT)
      pred_accum = {pred_accum[CpW-PayW-1:0], b[PayW-1:0]};
    else
      pred_accum = CpW'((8'hFF >> c) & b);
    s = dfa_advance(s, c);
    pred_state = s;
    r.cp  = (s == ST_ACCEPT) ? pred_accum : '0;
    r.st  = s;
    r.cc  = (s == ST_ACCEPT);
    r.rej = (s == ST_REJECT);
    r.sv  = last && (s == ST_ACCEPT);
    // End of string clears the decoder
    if (last) begin
      pred_state = ST_ACCEPT;
      pred_accum = '0;
    end
    return r;
  endfunction

  function automatic stim_row_t row(input logic [7:0] b, input logic last);
    stim_row_t t;
    t = '0;
    t.b    = b;
    t.last = last;
    return t;
  endfunction

  function automatic stim_row_t row_typed(input logic [7:0] b, input logic last,
                                          input logic [CpW-1:0] cp,
                                          input logic [StateW-1:0] st,
                                          input logic cc, input logic rej, input logic sv);
    stim_row_t t;
    t       = row(b, last);
    t.typed = 1'b1;
    t.res   = '{cp: cp, st: st, cc: cc, rej: rej, sv: sv};
    return t;
  endfunction

  // Random string: mostly well-formed characters, some noise and broken ones
  task automatic gen_string();
    logic [7:0] str_q[$];
    logic [7:0] lead, lo, hi, cb;
    int nchars, ncont, kind;
    nchars = $urandom_range(1, 8);
    for (int n = 0; n < nchars; n++) begin
      kind = $urandom_range(0, 99);
      lo = 8'h80;
      hi = 8'hBF;
      ncont = 0;
      if (kind < 28) begin
        lead = 8'($urandom_range(8'h00, 8'h7F));
      end else if (kind < 48) begin
        lead = 8'($urandom_range(8'hC2, 8'hDF));
        ncont = 1;
      end else if (kind < 72) begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        ncont = 2;
        if (lead == 8'hE0) lo = 8'hA0;
        if (lead == 8'hED) hi = 8'h9F;
      end else if (kind < 90) begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        ncont = 3;
        if (lead == 8'hF0) lo = 8'h90;
        if (lead == 8'hF4) hi = 8'h8F;
      end else begin
        lead = 8'($urandom_range(0, 255));
      end
      str_q.push_back(lead);
      for (int k = 0; k < ncont; k++) begin
        cb = (k == 0) ? 8'($urandom_range(lo, hi)) : 8'($urandom_range(8'h80, 8'hBF));
        kind = $urandom_range(0, 99);
        // Broken sequences: cut short or a wrong byte in the middle
        if (kind < 3) break;
        if (kind < 6) cb = 8'($urandom_range(0, 255));
        str_q.push_back(cb);
      end
    end
    foreach (str_q[i]) utf8_bytes.push_back(row(str_q[i], i == str_q.size() - 1));
  endtask

  // Offer one item and wait for it to be taken
  task automatic send_item(input stim_row_t t);
    dec_result_t r;
    if ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t.b;
    s_axis_tlast  <= t.last;
    do @(posedge clk); while (!s_axis_tready);
    r = decode_byte(t.b, t.last);
    expected_decodes.push_back(t.typed ? t.res : r);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin : result_mon
    dec_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_decodes.size() == 0) begin
        $error("result item with no expectation pending");
        err_cnt++;
      end else begin
        want = expected_decodes.pop_front();
        check_field("code_point", want.cp, m_axis_tdata[20:0]);
        check_field("dfa_state_out", want.st, m_axis_tdata[24:21]);
        check_field("tdata_pad", 0, m_axis_tdata[31:25]);
        check_field("char_complete", want.cc, m_axis_tuser[0]);
        check_field("rejected", want.rej, m_axis_tuser[1]);
        check_field("string_valid", want.sv, m_axis_tuser[2]);
      end
    end
  end

  // Receiver: random stalls plus one long hold-off once the fill test starts
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (fill_test && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
      @(negedge clk);
    end
  end

  // Reset, stimulus and end of run
  initial begin
    int n_items;
    int third;
    // Directed table
    utf8_bytes.push_back(row_typed(8'h00, 1'b1, 21'h0,  ST_ACCEPT, 1'b1, 1'b0, 1'b1));
    utf8_bytes.push_back(row_typed(8'h7F, 1'b1, 21'h7F, ST_ACCEPT, 1'b1, 1'b0, 1'b1));
    // lone continuation and invalid bytes reject at once
    utf8_bytes.push_back(row_typed(8'h80, 1'b1, 21'h0,  ST_REJECT, 1'b0, 1'b1, 1'b0));
    utf8_bytes.push_back(row_typed(8'hFF, 1'b1, 21'h0,  ST_REJECT, 1'b0, 1'b1, 1'b0));
    // smallest and largest two-byte characters
    utf8_bytes.push_back(row(8'hC2, 1'b0));
    utf8_bytes.push_back(row(8'h80, 1'b0));
    utf8_bytes.push_back(row(8'hDF, 1'b0));
    utf8_bytes.push_back(row(8'hBF, 1'b1));
    // smallest three-byte character
    utf8_bytes.push_back(row(8'hE0, 1'b0));
    utf8_bytes.push_back(row(8'hA0, 1'b0));
    utf8_bytes.push_back(row(8'h80, 1'b0));
    // surrogate rejects, then bytes keep shifting in past 21 bits
    utf8_bytes.push_back(row(8'hED, 1'b0));
    utf8_bytes.push_back(row(8'hA0, 1'b0));
    utf8_bytes.push_back(row(8'hBF, 1'b0));
    utf8_bytes.push_back(row(8'hBF, 1'b0));
    utf8_bytes.push_back(row(8'hBF, 1'b0));
    utf8_bytes.push_back(row(8'hBF, 1'b1));
    // highest code point
    utf8_bytes.push_back(row(8'hF4, 1'b0));
    utf8_bytes.push_back(row(8'h8F, 1'b0));
    utf8_bytes.push_back(row(8'hBF, 1'b0));
    utf8_bytes.push_back(row(8'hBF, 1'b0));
    // string ends inside a character
    utf8_bytes.push_back(row(8'hF0, 1'b0));
    utf8_bytes.push_back(row(8'h90, 1'b0));
    utf8_bytes.push_back(row(8'h80, 1'b1));
    utf8_bytes.push_back(row_typed(8'hC1, 1'b1, 21'h0, ST_REJECT, 1'b0, 1'b1, 1'b0));

    n_items = utf8_bytes.size() + RandomBytes;
    while (utf8_bytes.size() < n_items) gen_string();
    n_items = utf8_bytes.size();
    third   = n_items / 3;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (utf8_bytes[i]) begin
      if (i == third) begin
        send_idle = 82;
        recv_idle = 13;
      end else if (i == 2 * third) begin
        send_idle = 0;
        recv_idle = 0;
        fill_test = 1'b1;
      end
      send_item(utf8_bytes[i]);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
rtl/u8d_pkg.sv
rtl/u8d_front.sv
rtl/u8d_queue.sv
rtl/u8d_back.sv
rtl/utf8_dfa_decoder_unit.sv
sim/utf8_dfa_decoder_unit_test.sv
